// File: hw/rtl/sgbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbs_pkg: shared types and constants of the softmax bandit selector
// Widths, exp tables, controller states and the command and status structs
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sgbs_pkg;

  localparam int NUM_ARMS    = 3;
  localparam int ARM_W       = $clog2(NUM_ARMS);
  localparam int LOGIT_W     = 16;
  localparam int PROB_W      = 16;
  localparam int LR_W        = 16;
  localparam int REWARD_W    = 14;
  localparam int RND_W       = 16;
  localparam int E_W         = 17;                       // exp value, up to 65536
  localparam int SUM_W       = E_W + $clog2(NUM_ARMS);   // sum of all exp values
  localparam int Q_W         = 17;                       // quotient bits, up to 65536
  localparam int N_W         = E_W + 16 + 1;             // dividend width
  localparam int STEP_W      = $clog2(Q_W);
  localparam int MUL_A_W     = 31;
  localparam int MUL_B_W     = 19;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int DELTA_W     = MUL_P_W - 32 + 1;
  localparam int VSUM_W      = DELTA_W + 1;
  localparam int LOGIT_LIMIT = 20480;                    // 5.0 in Q3.12
  localparam int CFG_ADDR_W  = 3;

  localparam logic [LR_W-1:0] LR_RESET          = 16'd3277;
  localparam logic [0:0]      REG_LEARNING_RATE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_UPD_LR,
    ST_UPD_MUL,
    ST_UPD_RND,
    ST_UPD_ADD,
    ST_UPD_END,
    ST_EXP_T,
    ST_EXP_F,
    ST_EXP_W,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_WR,
    ST_DONE
  } st_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_UPD_LR,
    DP_UPD_MUL,
    DP_UPD_RND,
    DP_UPD_ADD,
    DP_EXP_T,
    DP_EXP_F,
    DP_EXP_W,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_WR,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [ARM_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic arm_ok;
    logic applied;
    logic out_free;
  } dp_status_t;

  // round(65536 * e^-n); zero once the span leaves the table.
  function automatic logic [E_W-1:0] iexp(input logic [3:0] n);
    logic [E_W-1:0] v;
    unique case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(65536 * e^(-f/16))
  function automatic logic [E_W-1:0] fexp(input logic [3:0] f);
    logic [E_W-1:0] v;
    unique case (f)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      4'd15: v = 17'd25664;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Starting preferences: 0.3 for arm 1, -0.1 for arm 2, zero elsewhere.
  function automatic logic signed [LOGIT_W-1:0] logit_reset(input int i);
    logic signed [LOGIT_W-1:0] v;
    v = '0;
    if (i == 1) v = 16'sd1229;
    if (i == 2) v = -16'sd410;
    return v;
  endfunction

endpackage

// File: hw/rtl/sgbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbs_ctrl: sequencer of the softmax bandit selector
// Walks the update pass, the exp pass, the serial divisions and the result
// handoff, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module sgbs_ctrl import sgbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  st_e               state_q, state_d;
  logic [ARM_W-1:0]  idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              pending_q, pending_d;
  logic              last_arm;

  assign last_arm = (idx_q == ARM_W'(NUM_ARMS - 1));

  // After reset the probabilities of the starting logits are computed first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_EXP_T;
      idx_q     <= '0;
      step_q    <= '0;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      step_q    <= step_d;
      pending_q <= pending_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    step_d     = step_q;
    pending_d  = pending_q;
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.idx  = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op  = DP_LOAD;
          pending_d = 1'b1;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        idx_d = '0;
        if (status_i.is_sample || !status_i.arm_ok) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_UPD_LR;
        end
      end
      ST_UPD_LR: begin
        cmd_o.op = DP_UPD_LR;
        state_d  = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        cmd_o.op = DP_UPD_MUL;
        state_d  = ST_UPD_RND;
      end
      ST_UPD_RND: begin
        cmd_o.op = DP_UPD_RND;
        state_d  = ST_UPD_ADD;
      end
      ST_UPD_ADD: begin
        cmd_o.op = DP_UPD_ADD;
        if (last_arm) begin
          idx_d   = '0;
          state_d = ST_UPD_END;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_UPD_MUL;
        end
      end
      ST_UPD_END: begin
        // Unchanged logits keep the probabilities already held.
        state_d = status_i.applied ? ST_EXP_T : ST_DONE;
      end
      ST_EXP_T: begin
        cmd_o.op = DP_EXP_T;
        state_d  = ST_EXP_F;
      end
      ST_EXP_F: begin
        cmd_o.op = DP_EXP_F;
        state_d  = ST_EXP_W;
      end
      ST_EXP_W: begin
        cmd_o.op = DP_EXP_W;
        if (last_arm) begin
          idx_d   = '0;
          state_d = ST_DIV_INIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_EXP_T;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.op = DP_DIV_INIT;
        step_d   = '0;
        state_d  = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.op = DP_DIV_STEP;
        if (step_q == STEP_W'(Q_W - 1)) begin
          state_d = ST_DIV_WR;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DIV_WR: begin
        cmd_o.op = DP_DIV_WR;
        if (last_arm) begin
          idx_d   = '0;
          state_d = pending_q ? ST_DONE : ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op  = DP_RESULT;
          pending_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/sgbs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbs_dpath: datapath of the softmax bandit selector
// Logit store, shared multiplier, exp tables, restoring divider, sample
// compare and the output register.
// ----------------------------------------------------------------------------
module sgbs_dpath import sgbs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  input  logic                       in_action_i,
  input  logic [1:0]                 in_arm_i,
  input  logic signed [REWARD_W-1:0] in_reward_i,
  input  logic [RND_W-1:0]           in_random_value_i,
  input  logic [LR_W-1:0]            learning_rate_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [1:0]                 out_chosen_arm_o,
  output logic                       out_update_applied_o,
  output logic [PROB_W-1:0]          out_weight_a_o,
  output logic [PROB_W-1:0]          out_weight_b_o,
  output logic [PROB_W-1:0]          out_weight_c_o
);

  // Item fields held for the length of the item.
  logic                       item_action_q;
  logic [1:0]                 item_arm_q;
  logic signed [REWARD_W-1:0] item_reward_q;
  logic [RND_W-1:0]           item_rnd_q;

  logic signed [LOGIT_W-1:0] logit_q [NUM_ARMS];
  logic [E_W-1:0]            e_q     [NUM_ARMS];
  logic [PROB_W-1:0]         p_q     [NUM_ARMS];
  logic [SUM_W-1:0]          sum_q;
  logic [E_W-1:0]            fine_q;
  logic signed [MUL_P_W-1:0] mul_q;
  logic signed [MUL_A_W-1:0] lrr_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [SUM_W-1:0]          rem_q;
  logic [Q_W-1:0]            quo_q;
  logic                      applied_q;

  logic                      out_valid_q;
  logic [1:0]                out_chosen_q;
  logic                      out_applied_q;
  logic [PROB_W-1:0]         out_weight_q [3];

  logic signed [LOGIT_W-1:0] mx;
  logic signed [LOGIT_W:0]   m_full;
  logic [15:0]               m;
  logic [15:0]               gg;
  logic [E_W-1:0]            fine_c;
  logic [E_W-1:0]            t;
  logic signed [17:0]        diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [MUL_P_W-1:0]        mag;
  logic [MUL_P_W-1:0]        mag_rnd;
  logic signed [DELTA_W-1:0] delta_c;
  logic signed [VSUM_W-1:0]  vsum;
  logic signed [LOGIT_W-1:0] logit_new;
  logic [N_W-1:0]            num;
  logic [SUM_W:0]            rem_sh;
  logic                      rem_ge;
  logic [SUM_W-1:0]          cum;
  logic                      hit;
  logic [ARM_W-1:0]          chosen;

  // Largest logit, subtracted before the exp lookup.
  always_comb begin
    mx = logit_q[0];
    for (int i = 1; i < NUM_ARMS; i++) begin
      if (logit_q[i] > mx) mx = logit_q[i];
    end
  end

  // exp(-m) = IEXP[n] * FEXP[f] * (65536 - 16*g + g^2/512), all in Q16.
  assign m_full = {mx[LOGIT_W-1], mx} - {logit_q[cmd_i.idx][LOGIT_W-1], logit_q[cmd_i.idx]};
  assign m      = m_full[15:0];
  assign gg     = m[7:0] * m[7:0];
  assign fine_c = 17'd65536 - {5'b0, m[7:0], 4'b0} + E_W'(gg >> 9);
  assign t      = mul_q[32:16];

  assign diff = ((32'(cmd_i.idx) == 32'(item_arm_q)) ? 18'sd65536 : 18'sd0)
              - $signed({2'b0, p_q[cmd_i.idx]});

  always_comb begin
    unique case (cmd_i.op)
      DP_EXP_T: begin
        mul_a = $signed({14'b0, iexp(m[15:12])});
        mul_b = $signed({2'b0, fexp(m[11:8])});
      end
      DP_EXP_F: begin
        mul_a = $signed({14'b0, t});
        mul_b = $signed({2'b0, fine_q});
      end
      DP_UPD_LR: begin
        mul_a = $signed({15'b0, learning_rate_i});
        mul_b = {{(MUL_B_W - REWARD_W){item_reward_q[REWARD_W-1]}}, item_reward_q};
      end
      DP_UPD_MUL: begin
        mul_a = lrr_q;
        mul_b = {diff[17], diff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Q44 step rounded to Q3.12, halves away from zero.
  assign mag     = mul_q[MUL_P_W-1] ? MUL_P_W'(-mul_q) : MUL_P_W'(mul_q);
  assign mag_rnd = mag + MUL_P_W'(64'h8000_0000);
  assign delta_c = mul_q[MUL_P_W-1] ? -$signed({1'b0, mag_rnd[MUL_P_W-1:32]})
                                    : $signed({1'b0, mag_rnd[MUL_P_W-1:32]});

  assign vsum = VSUM_W'(logit_q[cmd_i.idx]) + VSUM_W'(delta_q);

  always_comb begin
    if (vsum > VSUM_W'(LOGIT_LIMIT)) begin
      logit_new = LOGIT_W'(LOGIT_LIMIT);
    end else if (vsum < -VSUM_W'(LOGIT_LIMIT)) begin
      logit_new = -LOGIT_W'(LOGIT_LIMIT);
    end else begin
      logit_new = vsum[LOGIT_W-1:0];
    end
  end

  // Rounded division: (e * 65536 + S/2) / S, one quotient bit per step.
  assign num    = {e_q[cmd_i.idx], 16'b0} + N_W'(sum_q >> 1);
  assign rem_sh = {rem_q, quo_q[Q_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, sum_q});

  // Cumulative walk for a sample item; the last arm catches a miss.
  always_comb begin
    cum    = '0;
    hit    = 1'b0;
    chosen = ARM_W'(NUM_ARMS - 1);
    for (int i = 0; i < NUM_ARMS; i++) begin
      cum = cum + SUM_W'(p_q[i]);
      if (!hit && (SUM_W'(item_rnd_q) <= cum)) begin
        chosen = ARM_W'(i);
        hit    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ARMS; i++) logit_q[i] <= logit_reset(i);
      applied_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_LOAD) begin
        applied_q <= 1'b0;
      end else if (cmd_i.op == DP_UPD_ADD) begin
        logit_q[cmd_i.idx] <= logit_new;
        if (logit_new != logit_q[cmd_i.idx]) applied_q <= 1'b1;
      end
      if (cmd_i.op == DP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        item_action_q <= in_action_i;
        item_arm_q    <= in_arm_i;
        item_reward_q <= in_reward_i;
        item_rnd_q    <= in_random_value_i;
      end
      DP_UPD_LR: begin
        lrr_q <= mul_p[MUL_A_W-1:0];
      end
      DP_UPD_MUL: begin
        mul_q <= mul_p;
      end
      DP_UPD_RND: begin
        delta_q <= delta_c;
      end
      DP_EXP_T: begin
        mul_q  <= mul_p;
        fine_q <= fine_c;
      end
      DP_EXP_F: begin
        mul_q <= mul_p;
      end
      DP_EXP_W: begin
        e_q[cmd_i.idx] <= mul_q[32:16];
        sum_q <= ((cmd_i.idx == '0) ? '0 : sum_q) + SUM_W'(mul_q[32:16]);
      end
      DP_DIV_INIT: begin
        rem_q <= SUM_W'(num[N_W-1:Q_W]);
        quo_q <= num[Q_W-1:0];
      end
      DP_DIV_STEP: begin
        rem_q <= rem_ge ? SUM_W'(rem_sh - {1'b0, sum_q}) : rem_sh[SUM_W-1:0];
        quo_q <= {quo_q[Q_W-2:0], rem_ge};
      end
      DP_DIV_WR: begin
        p_q[cmd_i.idx] <= quo_q[Q_W-1] ? {PROB_W{1'b1}} : quo_q[PROB_W-1:0];
      end
      DP_RESULT: begin
        out_chosen_q  <= item_action_q ? 2'(chosen) : 2'd0;
        out_applied_q <= applied_q;
        for (int k = 0; k < 3; k++) begin
          out_weight_q[k] <= (k < NUM_ARMS) ? p_q[(k < NUM_ARMS) ? k : 0] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.is_sample = item_action_q;
  assign status_o.arm_ok    = (32'(item_arm_q) < 32'(NUM_ARMS));
  assign status_o.applied   = applied_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign out_chosen_arm_o     = out_chosen_q;
  assign out_update_applied_o = out_applied_q;
  assign out_weight_a_o       = out_weight_q[0];
  assign out_weight_b_o       = out_weight_q[1];
  assign out_weight_c_o       = out_weight_q[2];

endmodule

// File: hw/rtl/softmax_gradient_bandit_selector.sv
`timescale 1ns / 1ps
// Sample item, or update with invalid arm: no update, exp or division pass; the result
// goes to the output register and the next item is taken once it has been handed over.
// Update item: the update pass; only when a logit moves, also the exp pass and three
// 17-step divisions. Probabilities are held between items; a sample reuses them
// without recomputing. After reset the block computes the starting probabilities
// before accepting its first item; the learning rate register is writable throughout.
// ----------------------------------------------------------------------------
// softmax_gradient_bandit_selector: softmax arm selector with gradient update
// Top level: stream ports, learning rate register, controller and datapath.
// ----------------------------------------------------------------------------
module softmax_gradient_bandit_selector import sgbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [31:0]           s_axis_tdata_i,  // arm[1:0], reward[15:2], random_value[31:16]
  input  logic [0:0]            s_axis_tuser_i,  // action[0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [55:0]           m_axis_tdata_o,  // chosen_arm[1:0], update_applied[2],
                                                 // weight_a[18:3], weight_b[34:19],
                                                 // weight_c[50:35], zeros[55:51]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [LR_W-1:0]   lr_q;
  logic              reg_hit;
  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [1:0]        chosen_arm;
  logic              update_applied;
  logic [PROB_W-1:0] weight_a;
  logic [PROB_W-1:0] weight_b;
  logic [PROB_W-1:0] weight_c;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_LEARNING_RATE);
  assign prdata  = reg_hit ? {16'b0, lr_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      lr_q <= pwdata[LR_W-1:0];
    end
  end

  sgbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sgbs_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .in_action_i          (s_axis_tuser_i[0]),
    .in_arm_i             (s_axis_tdata_i[1:0]),
    .in_reward_i          ($signed(s_axis_tdata_i[15:2])),
    .in_random_value_i    (s_axis_tdata_i[31:16]),
    .learning_rate_i      (lr_q),
    .out_ready_i          (m_axis_tready_i),
    .out_valid_o          (m_axis_tvalid_o),
    .out_chosen_arm_o     (chosen_arm),
    .out_update_applied_o (update_applied),
    .out_weight_a_o       (weight_a),
    .out_weight_b_o       (weight_b),
    .out_weight_c_o       (weight_c)
  );

  assign m_axis_tdata_o = {5'b0, weight_c, weight_b, weight_a, update_applied, chosen_arm};

endmodule

// File: hw/rtl/sgbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbs_checker: port-level checks of the softmax bandit selector
// Watches the stream and register ports and is bound to the top level.
// ----------------------------------------------------------------------------
module sgbs_checker import sgbs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid_i,
  input logic                  s_tready_i,
  input logic                  m_tvalid_i,
  input logic                  m_tready_i,
  input logic [55:0]           m_tdata_i,
  input logic                  psel_i,
  input logic                  penable_i,
  input logic                  pwrite_i,
  input logic [CFG_ADDR_W-1:0] paddr_i,
  input logic [31:0]           pwdata_i,
  input logic [31:0]           prdata_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input taken again right after a transfer");

  // A drawn arm is always a real arm.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (32'(m_tdata_i[1:0]) < NUM_ARMS) || (NUM_ARMS > 4))
    else $error("chosen arm out of range");

  // Only update items report applied, and they report arm zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[2] |-> m_tdata_i[1:0] == 2'd0)
    else $error("applied flag on a sample result");

  // A learning rate write reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_LEARNING_RATE)
    |=> (paddr_i[2] != REG_LEARNING_RATE) || (prdata_i[15:0] == $past(pwdata_i[15:0])))
    else $error("learning rate readback mismatch");

endmodule

bind softmax_gradient_bandit_selector sgbs_checker u_sgbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .psel_i     (psel),
  .penable_i  (penable),
  .pwrite_i   (pwrite),
  .paddr_i    (paddr),
  .pwdata_i   (pwdata),
  .prdata_i   (prdata)
);

// File: dv/softmax_gradient_bandit_selector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_gradient_bandit_selector_test: self-checking bench for the selector
// Drives update and sample transfers on the input stream, writes registers over APB
// and reads the learning rate back. A softmax predictor in the bench mirrors the logits.
// Every output transfer is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module softmax_gradient_bandit_selector_test;
  import sgbs_pkg::*;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;
  localparam int   REG_UNUSED = 1;       // no register behind this index
  localparam int   NO_WRITE   = -1;
  localparam int   STALL_LIMIT   = 2000; // cycles without any transfer
  localparam int   SETTLE_CYCLES = 4;
  localparam int   TAIL_CYCLES   = 100;
  localparam int   ITEMS_PER_PHASE = 400;

  localparam longint WHOLE_EXP [11] = '{
    65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3
  };
  localparam longint FRAC_EXP [16] = '{
    65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
    39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664
  };

  // Same bit order as the low 51 bits of the output tdata.
  typedef struct packed {
    logic [PROB_W-1:0] weight_c;
    logic [PROB_W-1:0] weight_b;
    logic [PROB_W-1:0] weight_a;
    logic              update_applied;
    logic [1:0]        chosen_arm;
  } bandit_result_t;

  typedef struct {
    int         cfg_index;
    int         cfg_value;
    logic       act;
    logic [1:0] arm;
    int         reward;
    int         rnd;
    bit         pinned;
    logic [1:0] pin_arm;
    logic       pin_applied;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic [31:0]           s_data = '0;   // arm[1:0], reward[15:2], random_value[31:16]
  logic [0:0]            s_user = '0;   // action[0]
  logic                  m_ready = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [55:0]           m_axis_tdata_o; // chosen_arm[1:0], update_applied[2],
                                         // weight_a[18:3], weight_b[34:19],
                                         // weight_c[50:35], zeros[55:51]
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  wire in_fire  = s_valid && s_axis_tready_o;
  wire out_fire = m_axis_tvalid_o && m_ready;

  softmax_gradient_bandit_selector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Mirror of the block state.
  int                logit_q [NUM_ARMS];
  int unsigned       prob_q [NUM_ARMS];
  logic [LR_W-1:0]   rate_q;
  bandit_result_t    pending_results [$];

  int src_idle_pct = 25;
  int snk_stall_pct = 82;
  int error_count = 0;
  int results_seen = 0;
  int n_updates = 0;
  int n_invalid = 0;
  int n_samples = 0;
  int n_fallback = 0;
  int n_clamped = 0;

  plan_row_t directed_plan [23] = '{
    // A zero random value always lands on arm 0.
    '{NO_WRITE, 0, ACT_SAMPLE, 2'd0, 0, 0, 1'b1, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_SAMPLE, 2'd3, 0, 65535, 1'b0, 2'd0, 1'b0},
    // Invalid arm and zero reward leave the logits alone.
    '{NO_WRITE, 0, ACT_UPDATE, 2'd3, 6144, 12345, 1'b1, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd0, 0, 0, 1'b1, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd0, 6144, 0, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd1, -2048, 21845, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd2, 8191, 65535, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd2, -8192, 0, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_SAMPLE, 2'd1, 0, 32768, 1'b0, 2'd0, 1'b0},
    // A zero rate cannot move anything, and a write to an unused index keeps it zero.
    '{REG_LEARNING_RATE, 0, ACT_UPDATE, 2'd1, 6144, 0, 1'b1, 2'd0, 1'b0},
    '{REG_UNUSED, 12345, ACT_UPDATE, 2'd1, 6144, 0, 1'b1, 2'd0, 1'b0},
    // Full rate with full reward moves the logits by large steps.
    '{REG_LEARNING_RATE, 65535, ACT_UPDATE, 2'd0, 8191, 0, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd0, 8191, 0, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_SAMPLE, 2'd0, 0, 0, 1'b1, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_SAMPLE, 2'd2, 0, 65535, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd1, -8192, 0, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd2, 8191, 0, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd2, 8191, 0, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_SAMPLE, 2'd0, 0, 1, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_SAMPLE, 2'd1, 0, 65534, 1'b0, 2'd0, 1'b0},
    '{NO_WRITE, 0, ACT_UPDATE, 2'd3, -8192, 0, 1'b1, 2'd0, 1'b0},
    '{REG_LEARNING_RATE, 1, ACT_UPDATE, 2'd1, 1, 0, 1'b0, 2'd0, 1'b0},
    '{REG_LEARNING_RATE, LR_RESET, ACT_SAMPLE, 2'd0, 0, 40000, 1'b0, 2'd0, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // exp(-gap) in Q1.16 from the coarse and fine tables plus a quadratic term.
  function automatic longint exp_of_gap(input int gap);
    int     whole;
    int     frac;
    int     g;
    longint fine;
    longint t;
    whole = gap >> 12;
    frac  = (gap >> 8) & 15;
    g     = gap & 255;
    if (whole > 10) return 0;
    fine = 65536 - 16 * g + (g * g) / 512;
    t = (WHOLE_EXP[whole] * FRAC_EXP[frac]) >> 16;
    return (t * fine) >> 16;
  endfunction

  function automatic void refresh_probs();
    longint e [NUM_ARMS];
    longint s;
    longint q;
    int     mx;
    int     i;
    mx = logit_q[0];
    for (i = 1; i < NUM_ARMS; i++) if (logit_q[i] > mx) mx = logit_q[i];
    s = 0;
    for (i = 0; i < NUM_ARMS; i++) begin
      e[i] = exp_of_gap(mx - logit_q[i]);
      s += e[i];
    end
    for (i = 0; i < NUM_ARMS; i++) begin
      q = ((e[i] << 16) + s / 2) / s;
      prob_q[i] = (q > 65535) ? 32'd65535 : int'(q);
    end
  endfunction

  function automatic bandit_result_t softmax_step(input logic act, input logic [1:0] arm,
                                                  input logic signed [REWARD_W-1:0] reward,
                                                  input logic [RND_W-1:0] rnd);
    bandit_result_t r;
    longint         diff;
    longint         prod;
    longint         mag;
    longint         delta;
    longint         v;
    int unsigned    acc;
    bit             hit;
    int             i;
    r = '0;
    if (act == ACT_UPDATE) begin
      n_updates++;
      if (arm < NUM_ARMS) begin
        // All deltas use the probabilities from before this update.
        for (i = 0; i < NUM_ARMS; i++) begin
          diff  = ((i == arm) ? 65536 : 0) - longint'(prob_q[i]);
          prod  = longint'(rate_q) * longint'(reward) * diff;
          mag   = (prod < 0) ? -prod : prod;
          delta = (mag + (longint'(1) << 31)) >> 32;
          if (prod < 0) delta = -delta;
          v = longint'(logit_q[i]) + delta;
          if (v > LOGIT_LIMIT || v < -LOGIT_LIMIT) n_clamped++;
          if (v > LOGIT_LIMIT) v = LOGIT_LIMIT;
          if (v < -LOGIT_LIMIT) v = -LOGIT_LIMIT;
          if (v != logit_q[i]) r.update_applied = 1'b1;
          logit_q[i] = int'(v);
        end
        refresh_probs();
      end else begin
        n_invalid++;
      end
    end else begin
      n_samples++;
      r.chosen_arm = 2'(NUM_ARMS - 1);
      acc = 0;
      hit = 1'b0;
      for (i = 0; i < NUM_ARMS; i++) begin
        if (!hit) begin
          acc += prob_q[i];
          if (rnd <= acc) begin
            r.chosen_arm = 2'(i);
            hit = 1'b1;
          end
        end
      end
      if (!hit) n_fallback++;
    end
    r.weight_a = prob_q[0][PROB_W-1:0];
    r.weight_b = prob_q[1][PROB_W-1:0];
    r.weight_c = prob_q[2][PROB_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  // Writes one register, then reads back the learning rate in the following transfer.
  task automatic cfg_write(input int idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_LEARNING_RATE) rate_q = value[LR_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(4 * REG_LEARNING_RATE);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {{(32 - LR_W){1'b0}}, rate_q})
      report_mismatch($sformatf("learning rate reads %0d, expected %0d", prdata, rate_q));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_item(input logic act, input logic [1:0] arm,
                           input logic [REWARD_W-1:0] reward, input logic [RND_W-1:0] rnd,
                           input bit pinned, input logic [1:0] pin_arm,
                           input logic pin_applied);
    bandit_result_t want;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {rnd, reward, arm};
    s_user  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    want = softmax_step(act, arm, reward, rnd);
    if (pinned) begin
      want.chosen_arm     = pin_arm;
      want.update_applied = pin_applied;
    end
    pending_results = {pending_results, want};
  endtask

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    bandit_result_t got;
    bandit_result_t want;
    if (rst_ni && out_fire) begin
      got = m_axis_tdata_o[50:0];
      if (pending_results.size() == 0) begin
        report_mismatch("output transfer with no result pending");
      end else begin
        want = pending_results.pop_front();
        if (got.chosen_arm !== want.chosen_arm)
          report_mismatch($sformatf("chosen_arm %0d, expected %0d",
                                    got.chosen_arm, want.chosen_arm));
        if (got.update_applied !== want.update_applied)
          report_mismatch($sformatf("update_applied %0d, expected %0d",
                                    got.update_applied, want.update_applied));
        if (got.weight_a !== want.weight_a)
          report_mismatch($sformatf("weight_a %0d, expected %0d",
                                    got.weight_a, want.weight_a));
        if (got.weight_b !== want.weight_b)
          report_mismatch($sformatf("weight_b %0d, expected %0d",
                                    got.weight_b, want.weight_b));
        if (got.weight_c !== want.weight_c)
          report_mismatch($sformatf("weight_c %0d, expected %0d",
                                    got.weight_c, want.weight_c));
      end
      results_seen++;
    end
  end

  // The slowest gap between transfers is a full update behind a long receiver stall,
  // or the start-up pass; the limit leaves wide margin.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    plan_row_t             row;
    logic [1:0]            arm;
    logic                  act;
    logic [REWARD_W-1:0]   reward;
    int                    phase;
    int                    k;
    logit_q[0] = 0;
    logit_q[1] = 1229;
    logit_q[2] = -410;
    rate_q = LR_RESET;
    refresh_probs();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.cfg_index != NO_WRITE) begin
        wait_idle();
        cfg_write(row.cfg_index, row.cfg_value);
      end
      send_item(row.act, row.arm, REWARD_W'(row.reward), RND_W'(row.rnd),
                row.pinned, row.pin_arm, row.pin_applied);
    end

    for (phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          src_idle_pct  = 25;
          snk_stall_pct = 82;
          cfg_write(REG_LEARNING_RATE, $urandom_range(0, 65535));
        end
        1: begin
          src_idle_pct  = 82;
          snk_stall_pct = 25;
          cfg_write(REG_LEARNING_RATE, $urandom_range(1000, 8000));
        end
        default: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          cfg_write(REG_LEARNING_RATE, LR_RESET);
        end
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        act = $urandom_range(0, 1);
        arm = $urandom_range(0, 3);
        // Mostly rewards in the intended range, sometimes any 14-bit pattern.
        if ($urandom_range(0, 9) == 0) reward = $urandom_range(0, 16383);
        else reward = REWARD_W'($urandom_range(0, 8192) - 2048);
        send_item(act, arm, reward, RND_W'($urandom_range(0, 65535)), 1'b0, 2'd0, 1'b0);
      end
    end

    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d updates (%0d with an invalid arm, %0d clamped logits)",
             n_updates, n_invalid, n_clamped);
    $display("and %0d samples (%0d fell through to the last arm); %0d results checked",
             n_samples, n_fallback, results_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
